// ----- sv/segregated_bin_allocator_core_assert.svh -----
// Assertion macros for the segregated bin allocator core
`ifndef SEGREGATED_BIN_ALLOCATOR_CORE_ASSERT_SVH
`define SEGREGATED_BIN_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sba_pkg.sv -----
// Shared types, codes and defaults of the segregated bin allocator
package sba_pkg;

  localparam int unsigned DefClassBytes  = 16;
  localparam int unsigned DefNumClasses  = 8;
  localparam int unsigned DefHeaderBytes = 16;
  localparam int unsigned DefStackDepth  = 64;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_REALLOC = 2'd2,
    FUNC_RSVD    = 2'd3
  } sba_func_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NULL = 2'd1,
    STAT_OOM  = 2'd2,
    STAT_FULL = 2'd3
  } sba_status_e;

  // Work needed by one request
  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_FIT   = 3'd2,
    OP_NULL  = 3'd3,
    OP_MOVE  = 3'd4
  } sba_op_e;

  typedef struct packed {
    logic capture;
    logic do_alloc;
    logic do_pop;
    logic do_free;
    logic load_out;
  } sba_cmd_t;

  typedef struct packed {
    sba_op_e op_dec;
    logic    is_move;
    logic    alloc_pop;
    logic    alloc_ok;
  } sba_stat_t;

  typedef struct packed {
    logic        wr_base;
    logic        wr_bytes;
    logic [31:0] wdata;
  } sba_cfg_t;

endpackage

// ----- sv/sba_ctrl.sv -----
// Request sequencer of the segregated bin allocator
module sba_ctrl
  import sba_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  sba_stat_t stat_i,
  output sba_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ALLOC = 4'b0010,
    ST_POP   = 4'b0100,
    ST_FREE  = 4'b1000
  } sba_state_e;

  sba_state_e state_q, state_d;
  logic       res_valid_q, res_valid_d;
  logic       out_valid_q, out_valid_d;
  logic       emit, capture, finish, in_ready;

  always_comb begin
    emit     = res_valid_q && (!out_valid_q || out_ready_i);
    in_ready = (state_q == ST_IDLE) && (!res_valid_q || emit);
    capture  = in_valid_i && in_ready;
    finish   = 1'b0;
    state_d  = state_q;
    case (state_q)
      ST_IDLE: begin
        if (capture) begin
          case (stat_i.op_dec)
            OP_ALLOC, OP_MOVE: state_d = ST_ALLOC;
            OP_FREE:           state_d = ST_FREE;
            default:           finish  = 1'b1;
          endcase
        end
      end
      ST_ALLOC: begin
        if (stat_i.alloc_pop) begin
          state_d = ST_POP;
        end else if (stat_i.alloc_ok && stat_i.is_move) begin
          state_d = ST_FREE;
        end else begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        if (stat_i.is_move) begin
          state_d = ST_FREE;
        end else begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FREE: begin
        finish  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    res_valid_d = (res_valid_q && !emit) || finish;
    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o     = in_ready;
  assign out_valid_o    = out_valid_q;
  assign cmd_o.capture  = capture;
  assign cmd_o.do_alloc = (state_q == ST_ALLOC);
  assign cmd_o.do_pop   = (state_q == ST_POP);
  assign cmd_o.do_free  = (state_q == ST_FREE);
  assign cmd_o.load_out = emit;

endmodule

// ----- sv/sba_dp.sv -----
// Datapath of the segregated bin allocator: arena, bin stacks and result registers
module sba_dp
  import sba_pkg::*;
#(
  parameter int unsigned CLASS_BYTES  = DefClassBytes,
  parameter int unsigned NUM_CLASSES  = DefNumClasses,
  parameter int unsigned HEADER_BYTES = DefHeaderBytes,
  parameter int unsigned STACK_DEPTH  = DefStackDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  func_i,
  input  logic [31:0] request_size_i,
  input  logic [31:0] block_addr_i,
  input  logic [31:0] block_size_i,
  input  sba_cmd_t    cmd_i,
  input  sba_cfg_t    cfg_i,
  output sba_stat_t   stat_o,
  output logic [31:0] arena_base_o,
  output logic [31:0] arena_bytes_o,
  output logic [31:0] result_addr_o,
  output logic [31:0] granted_size_o,
  output logic [1:0]  status_o,
  output logic        copy_needed_o,
  output logic [31:0] copy_bytes_o
);

  localparam int unsigned CLW       = $clog2(NUM_CLASSES + 1);
  localparam int unsigned CIW       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned FW        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
  localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [AW-1:0]  DepthA   = AW'(STACK_DEPTH);
  localparam logic [CLW-1:0] ClassLim = CLW'(NUM_CLASSES);
  localparam logic [FW-1:0]  FillMax  = FW'(STACK_DEPTH);

  // Size class by threshold compare; NUM_CLASSES marks a large size
  function automatic logic [CLW-1:0] class_of(input logic [31:0] size);
    logic [31:0]    x;
    logic [CLW-1:0] c;
    x = size - 32'd1;
    c = '0;
    if (size != 32'd0) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        if (x >= 32'((k + 1) * CLASS_BYTES)) c = CLW'(k + 1);
      end
    end
    return c;
  endfunction

  // Rounded bin payload of a size, valid when the size is nonzero and its class is small
  function automatic logic [31:0] bin_payload(input logic [31:0] size);
    logic [31:0] x;
    logic [31:0] p;
    x = size - 32'd1;
    p = 32'(CLASS_BYTES);
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (x >= 32'((k + 1) * CLASS_BYTES)) p = 32'((k + 2) * CLASS_BYTES);
    end
    return p;
  endfunction

  // Configuration and arena state
  logic [31:0] arena_base_q, arena_bytes_q, bump_q;
  logic [FW-1:0] fill_q [NUM_CLASSES];

  // Captured request
  sba_op_e        op_q, op_dec;
  logic [31:0]    req_q, baddr_q, bsize_q, payload_q;
  logic [32:0]    needed_q;
  logic [CLW-1:0] creq_q, cblk_q;

  // Pending result and output stage
  logic [31:0] res_addr_q, res_gsize_q, res_cbytes_q;
  sba_status_e res_status_q;
  logic        res_copy_q;
  logic [31:0] out_addr_q, out_gsize_q, out_cbytes_q;
  sba_status_e out_status_q;
  logic        out_copy_q;

  // Bin stack memory
  logic [31:0]   stack_mem [MEM_DEPTH];
  logic [31:0]   mem_rd_q;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic          mem_re, mem_we;

  // Step decisions
  logic [CLW-1:0] creq_d;
  logic [31:0]    payload_d;
  logic [CIW-1:0] cidx, bidx;
  logic [FW-1:0]  fill_req, fill_blk;
  logic           req_small, blk_small, null_req, pop, oom, alloc_ok;
  logic           push, blk_full;
  logic [33:0]    bump_sum;
  logic [31:0]    arena_addr;
  sba_status_e    free_status;

  always_comb begin
    op_dec = OP_NULL;
    case (sba_func_e'(func_i))
      FUNC_ALLOC: op_dec = OP_ALLOC;
      FUNC_FREE:  op_dec = OP_FREE;
      FUNC_REALLOC: begin
        if (block_addr_i == 32'd0) begin
          op_dec = OP_ALLOC;
        end else if (request_size_i == 32'd0) begin
          op_dec = OP_FREE;
        end else if (block_size_i >= request_size_i) begin
          op_dec = OP_FIT;
        end else begin
          op_dec = OP_MOVE;
        end
      end
      default: op_dec = OP_NULL;
    endcase
    creq_d    = class_of(request_size_i);
    payload_d = (creq_d < ClassLim) ? bin_payload(request_size_i) : request_size_i;
  end

  always_comb begin
    cidx       = creq_q[CIW-1:0];
    bidx       = cblk_q[CIW-1:0];
    req_small  = creq_q < ClassLim;
    blk_small  = cblk_q < ClassLim;
    fill_req   = fill_q[cidx];
    fill_blk   = fill_q[bidx];
    null_req   = (req_q == 32'd0) || (arena_bytes_q == 32'd0);
    pop        = cmd_i.do_alloc && !null_req && req_small && (fill_req != '0);
    bump_sum   = {2'b00, bump_q} + {1'b0, needed_q};
    oom        = bump_sum > {2'b00, arena_bytes_q};
    alloc_ok   = !null_req && ((req_small && (fill_req != '0)) || !oom);
    arena_addr = arena_base_q + bump_q + 32'(HEADER_BYTES);
    blk_full   = fill_blk >= FillMax;
    push       = cmd_i.do_free && (baddr_q != 32'd0) && blk_small && !blk_full;
    if (baddr_q == 32'd0) begin
      free_status = STAT_NULL;
    end else if (!blk_small) begin
      free_status = STAT_OK;
    end else if (blk_full) begin
      free_status = STAT_FULL;
    end else begin
      free_status = STAT_OK;
    end
    mem_re    = pop;
    mem_we    = push;
    mem_raddr = AW'(cidx) * DepthA + AW'(fill_req - FW'(1));
    mem_waddr = AW'(bidx) * DepthA + AW'(fill_blk);
  end

  // Configuration, bump pointer and bin fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_base_q  <= '0;
      arena_bytes_q <= '0;
      bump_q        <= '0;
      fill_q        <= '{default: '0};
    end else begin
      if (cfg_i.wr_base) begin
        arena_base_q <= cfg_i.wdata;
      end
      if (cfg_i.wr_bytes) begin
        arena_bytes_q <= cfg_i.wdata;
        bump_q        <= '0;
      end else if (cmd_i.do_alloc && !pop && alloc_ok) begin
        bump_q <= bump_sum[31:0];
      end
      if (pop) begin
        fill_q[cidx] <= fill_req - FW'(1);
      end
      if (push) begin
        fill_q[bidx] <= fill_blk + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= baddr_q;
    end
    if (mem_re) begin
      mem_rd_q <= stack_mem[mem_raddr];
    end
  end

  // Request capture and result assembly
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_dec;
      req_q     <= request_size_i;
      baddr_q   <= block_addr_i;
      bsize_q   <= block_size_i;
      creq_q    <= creq_d;
      cblk_q    <= class_of(block_size_i);
      payload_q <= payload_d;
      needed_q  <= 33'(HEADER_BYTES) + {1'b0, payload_d};
      res_copy_q   <= 1'b0;
      res_cbytes_q <= '0;
      if (op_dec == OP_FIT) begin
        res_addr_q   <= block_addr_i;
        res_gsize_q  <= block_size_i;
        res_status_q <= STAT_OK;
      end else begin
        res_addr_q   <= '0;
        res_gsize_q  <= '0;
        res_status_q <= STAT_NULL;
      end
    end
    if (cmd_i.do_alloc && !null_req) begin
      if (alloc_ok) begin
        res_gsize_q  <= payload_q;
        res_status_q <= STAT_OK;
        if (!pop) begin
          res_addr_q <= arena_addr;
        end
        if (op_q == OP_MOVE) begin
          res_copy_q   <= 1'b1;
          res_cbytes_q <= bsize_q;
        end
      end else begin
        res_status_q <= STAT_OOM;
      end
    end
    if (cmd_i.do_pop) begin
      res_addr_q <= mem_rd_q;
    end
    if (cmd_i.do_free) begin
      res_status_q <= free_status;
    end
    if (cmd_i.load_out) begin
      out_addr_q   <= res_addr_q;
      out_gsize_q  <= res_gsize_q;
      out_status_q <= res_status_q;
      out_copy_q   <= res_copy_q;
      out_cbytes_q <= res_cbytes_q;
    end
  end

  assign stat_o.op_dec    = op_dec;
  assign stat_o.is_move   = (op_q == OP_MOVE);
  assign stat_o.alloc_pop = pop;
  assign stat_o.alloc_ok  = alloc_ok;

  assign arena_base_o   = arena_base_q;
  assign arena_bytes_o  = arena_bytes_q;
  assign result_addr_o  = out_addr_q;
  assign granted_size_o = out_gsize_q;
  assign status_o       = out_status_q;
  assign copy_needed_o  = out_copy_q;
  assign copy_bytes_o   = out_cbytes_q;

endmodule

// ----- sv/segregated_bin_allocator_core.sv -----
// Top level of the segregated bin allocator: register port, sequencer and datapath
// Usage:
//   Requests arrive on the in_valid_i/in_ready_o channel (func, request_size,
//   block_addr, block_size); each request yields exactly one result item on the
//   out_valid_o/out_ready_i channel (result_addr, granted_size, status,
//   copy_needed, copy_bytes). Program arena_base and arena_bytes over the APB
//   port while the block is idle; writing arena_bytes restarts the bump arena.
//   Work steps per item: none for a reallocate that fits or an unused code;
//   allocate for a bump allocate; free for a free; allocate and pop for an
//   allocate served from a bin; allocate, pop if from a bin, then free for a
//   reallocate that moves. Pop is a step of its own as the bin stack read port
//   is registered. A result goes into the holding register, then the output one.
//   Reset clears the arena registers, the bump offset and every bin fill count;
//   the stack memory itself needs no clearing and is read only below a fill.
//   A result waits in a holding register while the output register is stalled,
//   so the next item is still taken; in_ready_o drops while an item is being
//   worked and while both registers are full.
module segregated_bin_allocator_core
  import sba_pkg::*;
#(
  parameter int unsigned CLASS_BYTES  = DefClassBytes,
  parameter int unsigned NUM_CLASSES  = DefNumClasses,
  parameter int unsigned HEADER_BYTES = DefHeaderBytes,
  parameter int unsigned STACK_DEPTH  = DefStackDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] request_size_i,
  input  logic [31:0] block_addr_i,
  input  logic [31:0] block_size_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_addr_o,
  output logic [31:0] granted_size_o,
  output logic [1:0]  status_o,
  output logic        copy_needed_o,
  output logic [31:0] copy_bytes_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sba_cmd_t    cmd;
  sba_stat_t   stat;
  sba_cfg_t    cfg;
  logic [31:0] arena_base, arena_bytes;
  logic        cfg_wr;

  // Register map: arena_base at 0, arena_bytes at 4; word select is paddr[2]
  assign cfg_wr       = psel && penable && pwrite;
  assign cfg.wr_base  = cfg_wr && !paddr[2];
  assign cfg.wr_bytes = cfg_wr && paddr[2];
  assign cfg.wdata    = pwdata;
  assign prdata       = paddr[2] ? arena_bytes : arena_base;
  assign pready       = 1'b1;

  sba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sba_dp #(
    .CLASS_BYTES  (CLASS_BYTES),
    .NUM_CLASSES  (NUM_CLASSES),
    .HEADER_BYTES (HEADER_BYTES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .func_i         (func_i),
    .request_size_i (request_size_i),
    .block_addr_i   (block_addr_i),
    .block_size_i   (block_size_i),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .stat_o         (stat),
    .arena_base_o   (arena_base),
    .arena_bytes_o  (arena_bytes),
    .result_addr_o  (result_addr_o),
    .granted_size_o (granted_size_o),
    .status_o       (status_o),
    .copy_needed_o  (copy_needed_o),
    .copy_bytes_o   (copy_bytes_o)
  );

  `include "segregated_bin_allocator_core_assert.svh"

  // Capture and the work steps never overlap
  `SBA_ASSERT_IMPL(a_steps_exclusive, clk_i, rst_ni, 1'b1, $onehot0({cmd.capture, cmd.do_alloc, cmd.do_pop, cmd.do_free}), "sba: overlapping work steps")

  // A pop step only follows an allocate that took an entry from a bin
  `SBA_ASSERT_IMPL(a_pop_after_alloc, clk_i, rst_ni, cmd.do_pop, $past(cmd.do_alloc && stat.alloc_pop), "sba: pop without bin allocate")

  // A free right after an allocate is the second half of a successful move
  `SBA_ASSERT_IMPL(a_free_after_move, clk_i, rst_ni, cmd.do_free && $past(cmd.do_alloc), $past(stat.alloc_ok && stat.is_move), "sba: free after failed or non-move allocate")

  // A result handed to the output register is presented next cycle
  `SBA_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, cmd.load_out, out_valid_o, "sba: loaded result not presented")

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench of the segregated bin allocator: directed cases, then random traffic
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sba_pkg::*;

  localparam int unsigned CLASS_BYTES    = DefClassBytes;
  localparam int unsigned NUM_CLASSES    = DefNumClasses;
  localparam int unsigned HEADER_BYTES   = DefHeaderBytes;
  localparam int unsigned STACK_DEPTH    = DefStackDepth;
  localparam int unsigned TIMEOUT_CYCLES = 300000;
  // Drain time after the last result: covers the deepest item plus output registers
  localparam int unsigned SETTLE_CYCLES  = 8;

  // Register byte addresses on the APB port
  localparam logic [2:0] REG_ARENA_BASE  = 3'd0;
  localparam logic [2:0] REG_ARENA_BYTES = 3'd4;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] gsize;
    sba_status_e status;
    logic        copy;
    logic [31:0] cbytes;
  } grant_t;

  // A block the random traffic currently owns
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] size;
  } held_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i         = '0;
  logic [31:0] request_size_i = '0;
  logic [31:0] block_addr_i   = '0;
  logic [31:0] block_size_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [31:0] result_addr_o;
  logic [31:0] granted_size_o;
  logic [1:0]  status_o;
  logic        copy_needed_o;
  logic [31:0] copy_bytes_o;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the allocator state, advanced as each item is accepted
  logic [31:0] arena_base_q  = '0;
  logic [31:0] arena_bytes_q = '0;
  logic [31:0] bump_q        = '0;
  logic [31:0] bin_mem [NUM_CLASSES*STACK_DEPTH];
  int unsigned bin_fill [NUM_CLASSES];

  grant_t      pending_grants [$];
  held_t       live_blocks [$];
  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  // Set for a stretch of the run in which neither side idles
  logic        calm         = 1'b0;

  segregated_bin_allocator_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .request_size_i (request_size_i),
    .block_addr_i   (block_addr_i),
    .block_size_i   (block_size_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_addr_o  (result_addr_o),
    .granted_size_o (granted_size_o),
    .status_o       (status_o),
    .copy_needed_o  (copy_needed_o),
    .copy_bytes_o   (copy_bytes_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bound the run in case a handshake never completes
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Size class of a payload; NUM_CLASSES stands for too large for any bin
  function automatic int unsigned size_class(logic [31:0] sz);
    logic [31:0] c;
    if (sz == 0) return 0;
    c = (sz - 1) / CLASS_BYTES;
    return (c < NUM_CLASSES) ? c : NUM_CLASSES;
  endfunction

  // Pop from the bin if it holds anything, else carve header plus payload from the arena
  function automatic sba_status_e carve(input logic [31:0] sz, output logic [31:0] a,
                                        output logic [31:0] g);
    int unsigned c;
    logic [63:0] payload;
    logic [63:0] need;
    a = '0;
    g = '0;
    if (sz == 0 || arena_bytes_q == 0) return STAT_NULL;
    c = size_class(sz);
    payload = {32'd0, sz};
    if (c < NUM_CLASSES) begin
      payload = 64'(c + 1) * CLASS_BYTES;
      if (bin_fill[c] > 0) begin
        bin_fill[c]--;
        a = bin_mem[c*STACK_DEPTH + bin_fill[c]];
        g = payload[31:0];
        return STAT_OK;
      end
    end
    need = HEADER_BYTES + payload;
    if ({32'd0, bump_q} + need > {32'd0, arena_bytes_q}) return STAT_OOM;
    // The payload address wraps at 2^32
    a = 32'({32'd0, arena_base_q} + {32'd0, bump_q} + HEADER_BYTES);
    g = payload[31:0];
    bump_q = 32'({32'd0, bump_q} + need);
    return STAT_OK;
  endfunction

  // Push a freed block onto its bin; large blocks vanish, a full bin drops the address
  function automatic sba_status_e release_block(logic [31:0] addr, logic [31:0] sz);
    int unsigned c;
    if (addr == 0) return STAT_NULL;
    c = size_class(sz);
    if (c >= NUM_CLASSES) return STAT_OK;
    if (bin_fill[c] >= STACK_DEPTH) return STAT_FULL;
    bin_mem[c*STACK_DEPTH + bin_fill[c]] = addr;
    bin_fill[c]++;
    return STAT_OK;
  endfunction

  function automatic grant_t predict_grant(logic [1:0] f, logic [31:0] req,
                                           logic [31:0] addr, logic [31:0] bsize);
    grant_t r;
    r = '0;
    r.status = STAT_NULL;
    case (f)
      FUNC_ALLOC: r.status = carve(req, r.addr, r.gsize);
      FUNC_FREE:  r.status = release_block(addr, bsize);
      FUNC_REALLOC: begin
        if (addr == 0) begin
          r.status = carve(req, r.addr, r.gsize);
        end else if (req == 0) begin
          r.status = release_block(addr, bsize);
        end else if (bsize >= req) begin
          r.addr   = addr;
          r.gsize  = bsize;
          r.status = STAT_OK;
        end else begin
          // Allocate first, so the pop may come from the bin the old block joins
          r.status = carve(req, r.addr, r.gsize);
          if (r.status == STAT_OK) begin
            r.copy   = 1'b1;
            r.cbytes = bsize;
            r.status = release_block(addr, bsize);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until taken, then log what the block must answer
  task automatic send_req(logic [1:0] f, logic [31:0] req, logic [31:0] addr,
                          logic [31:0] bsize, output grant_t g);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= f;
    request_size_i <= req;
    block_addr_i   <= addr;
    block_size_i   <= bsize;
    do @(posedge clk_i); while (!in_ready_o);
    g = predict_grant(f, req, addr, bsize);
    pending_grants.push_back(g);
  endtask

  // Drop valid and wait until every result is in and the pipeline is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register, then read it back over the same port
  task automatic write_arena_reg(logic [2:0] a, logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== d) begin
      $display("%0t: register 0x%0h readback mismatch: expected 0x%08h, actual 0x%08h",
               $time, a, d, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_arena(logic [31:0] base, logic [31:0] bytes);
    settle();
    write_arena_reg(REG_ARENA_BASE, base);
    arena_base_q = base;
    write_arena_reg(REG_ARENA_BYTES, bytes);
    arena_bytes_q = bytes;
    bump_q = '0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver
  // ---------------------------------------------------------------------------

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : grant_check
    grant_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual addr 0x%08h status %0d",
                 $time, result_addr_o, status_o);
        errors++;
      end else begin
        want = pending_grants.pop_front();
        compare_field("result_addr", want.addr, result_addr_o);
        compare_field("granted_size", want.gsize, granted_size_o);
        compare_field("status", 32'(want.status), 32'(status_o));
        compare_field("copy_needed", 32'(want.copy), 32'(copy_needed_o));
        compare_field("copy_bytes", want.cbytes, copy_bytes_o);
      end
    end
    // Stall the result side now and then, except in the calm stretch
    out_ready_i <= calm || ($urandom_range(99) >= 17);
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Before any arena is set: allocations fail, frees still reach the bins
  task automatic test_uninitialised();
    grant_t g;
    send_req(FUNC_ALLOC, 32'd16, 32'd0, 32'd0, g);
    send_req(FUNC_REALLOC, 32'd32, 32'd0, 32'd0, g);
    send_req(FUNC_FREE, 32'd0, 32'h0000_0100, 32'd16, g);
    send_req(FUNC_FREE, 32'd0, 32'd0, 32'd16, g);
  endtask

  // Class boundaries, zero and large sizes, the unused code
  task automatic test_size_classes();
    grant_t g;
    program_arena(32'h0000_1000, 32'h0001_0000);
    send_req(FUNC_ALLOC, 32'd0, 32'd0, 32'd0, g);
    send_req(FUNC_ALLOC, 32'd1, 32'd0, 32'd0, g);   // pops the block freed before init
    send_req(FUNC_ALLOC, 32'd1, 32'd0, 32'd0, g);
    send_req(FUNC_ALLOC, 32'd16, 32'd0, 32'd0, g);
    send_req(FUNC_ALLOC, 32'd17, 32'd0, 32'd0, g);
    send_req(FUNC_ALLOC, 32'd128, 32'd0, 32'd0, g);
    send_req(FUNC_ALLOC, 32'd129, 32'd0, 32'd0, g);
    send_req(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'd0, g);
    send_req(FUNC_FREE, 32'd0, 32'h0000_7770, 32'd0, g);          // size zero joins class 0
    send_req(FUNC_FREE, 32'd0, 32'h0000_7780, 32'hFFFF_FFFF, g);  // large: ignored
    send_req(FUNC_FREE, 32'd0, 32'h0000_7790, 32'd129, g);
    send_req(FUNC_ALLOC, 32'd8, 32'd0, 32'd0, g);
    send_req(FUNC_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, g);
  endtask

  task automatic test_realloc();
    grant_t g;
    send_req(FUNC_REALLOC, 32'd40, 32'd0, 32'd0, g);               // null address: allocate
    send_req(FUNC_REALLOC, 32'd0, 32'h0000_2000, 32'd48, g);       // size zero: free
    send_req(FUNC_REALLOC, 32'd64, 32'h0000_3000, 32'd64, g);      // fits exactly
    send_req(FUNC_REALLOC, 32'd65, 32'h0000_3000, 32'd64, g);      // moves
    send_req(FUNC_FREE, 32'd0, 32'h0000_4000, 32'd20, g);
    send_req(FUNC_REALLOC, 32'd32, 32'h0000_5000, 32'd17, g);      // pop and push same bin
  endtask

  // Exhaustion, address wrap and the register extremes
  task automatic test_arena_limits();
    grant_t g;
    program_arena(32'hFFFF_FFF0, 32'd400);
    send_req(FUNC_ALLOC, 32'd200, 32'd0, 32'd0, g);
    send_req(FUNC_ALLOC, 32'd168, 32'd0, 32'd0, g);
    send_req(FUNC_ALLOC, 32'd130, 32'd0, 32'd0, g);
    send_req(FUNC_REALLOC, 32'd200, 32'h0000_6000, 32'd1, g);      // allocate fails
    send_req(FUNC_REALLOC, 32'd1, 32'h0000_6000, 32'd1, g);
    program_arena(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(FUNC_ALLOC, 32'hFFFF_FFEF, 32'd0, 32'd0, g);          // fills the arena exactly
    send_req(FUNC_ALLOC, 32'd200, 32'd0, 32'd0, g);
  endtask

  // Fill one bin to overflow, then move a block whose push is dropped
  task automatic test_bin_full();
    grant_t g;
    program_arena(32'h0010_0000, 32'h0010_0000);
    for (int i = 0; i <= STACK_DEPTH; i++) begin
      send_req(FUNC_FREE, 32'd0, 32'h0000_8000 + 32'(16 * i), 32'(97 + i % 16), g);
    end
    send_req(FUNC_REALLOC, 32'd300, 32'h0000_9000, 32'd112, g);
    send_req(FUNC_REALLOC, 32'd110, 32'h0000_A000, 32'd100, g);
    send_req(FUNC_ALLOC, 32'd100, 32'd0, 32'd0, g);
    send_req(FUNC_ALLOC, 32'd100, 32'd0, 32'd0, g);
  endtask

  // Mostly bin sizes, some large ones, rarely any 32-bit value
  function automatic logic [31:0] draw_size(int unsigned cap);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(NUM_CLASSES * CLASS_BYTES, 1);
    if (r < 95) return $urandom_range(cap, 1);
    return $urandom;
  endfunction

  // Well-formed alloc/free/realloc traffic over the blocks held, with some noise
  task automatic test_random_traffic(int unsigned n_items, int unsigned cap);
    grant_t      g;
    held_t       h;
    int unsigned pick;
    int unsigned idx;
    logic [31:0] sz;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 40 || (pick < 85 && live_blocks.size() == 0)) begin
        send_req(FUNC_ALLOC, draw_size(cap), $urandom, $urandom, g);
        if (g.status == STAT_OK && g.addr != 0) live_blocks.push_back(held_t'{g.addr, g.gsize});
      end else if (pick < 65) begin
        idx = $urandom_range(live_blocks.size() - 1);
        h = live_blocks[idx];
        live_blocks.delete(idx);
        send_req(FUNC_FREE, $urandom, h.addr, h.size, g);
      end else if (pick < 85) begin
        idx = $urandom_range(live_blocks.size() - 1);
        h = live_blocks[idx];
        case ($urandom_range(7))
          0:       sz = '0;
          1, 2, 3: sz = $urandom_range(h.size, 1);
          default: sz = draw_size(cap);
        endcase
        send_req(FUNC_REALLOC, sz, h.addr, h.size, g);
        // A fit keeps the entry; a free or a move retires the old block
        if (sz == 0 || g.copy) live_blocks.delete(idx);
        if (g.copy && g.addr != 0) live_blocks.push_back(held_t'{g.addr, g.gsize});
      end else begin
        case ($urandom_range(3))
          0: send_req(FUNC_FREE, $urandom, ($urandom_range(7) == 0) ? 32'd0 : $urandom,
                      ($urandom_range(1) == 0) ? draw_size(cap) : $urandom, g);
          1: send_req(FUNC_RSVD, $urandom, $urandom, $urandom, g);
          2: send_req(FUNC_REALLOC, draw_size(cap), $urandom, $urandom, g);
          default: send_req(FUNC_ALLOC, ($urandom_range(1) == 0) ? 32'd0 : $urandom,
                            $urandom, $urandom, g);
        endcase
      end
    end
  endtask

  initial begin
    foreach (bin_fill[i]) bin_fill[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_uninitialised();
    test_size_classes();
    test_realloc();
    test_arena_limits();
    test_bin_full();

    // Tight arena: exhaustion and bin reuse dominate
    program_arena(32'h0000_1000, 32'd4096);
    test_random_traffic(140, 300);
    // Wrapping base, largest arena, no idling on either side
    calm = 1'b1;
    program_arena(32'hFFFF_FF00, 32'hFFFF_FFFF);
    test_random_traffic(140, 4000);
    calm = 1'b0;
    // Arena off again: allocations fail, frees still fill the bins
    program_arena(32'h0000_0000, 32'h0000_0000);
    test_random_traffic(60, 300);
    program_arena(32'hFFFF_FFFF, 32'd65536);
    test_random_traffic(150, 1000);
    program_arena($urandom, $urandom_range(32'h0010_0000, 32'd8192));
    test_random_traffic(160, 2000);

    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
